// ===== src/fdo_pkg.sv =====
// Shared constants, types and helpers for the drop-oldest frame FIFO.
package fdo_pkg;

   localparam int DEPTH        = 16;
   localparam int HANDLE_BITS  = 32;
   localparam int PTR_BITS     = $clog2(DEPTH);
   localparam int CNT_BITS     = $clog2(DEPTH + 1);
   localparam int REG_BITS     = 5;
   localparam int FRAME_BITS   = 32;
   localparam int WIDE_BITS    = (CNT_BITS > REG_BITS) ? CNT_BITS : REG_BITS;
   localparam int CSR_IDX_BITS = 1;

   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_ENTRIES   = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_DISCARD_COUNT = CSR_IDX_BITS'(1);

   localparam logic ACTION_PUSH = 1'b0;
   localparam logic ACTION_POP  = 1'b1;

   localparam logic [REG_BITS-1:0] MAX_ENTRIES_RST   = REG_BITS'(16);
   localparam logic [REG_BITS-1:0] DISCARD_COUNT_RST = REG_BITS'(1);

   typedef struct packed {
      logic [REG_BITS-1:0] max_entries;
      logic [REG_BITS-1:0] discard_count;
   } cfg_type;

   typedef struct packed {
      logic                strobe;
      logic                frame_valid;
      logic [REG_BITS-1:0] dropped;
      logic [REG_BITS-1:0] occupancy;
   } rsp_type;

   function automatic logic [PTR_BITS-1:0] next_ptr(input logic [PTR_BITS-1:0] p);
      next_ptr = (p == PTR_BITS'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

endpackage

// ===== src/fdo_ram.sv =====
// Generic single-clock RAM: one write port, one read port with registered data.
module fdo_ram #(
   parameter int WORDS = 16,
   parameter int WIDTH = 32,
   parameter int ABITS = $clog2(WORDS)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [ABITS-1:0] waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [ABITS-1:0] raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [WORDS];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/fdo_ctrl.sv =====
// Pointer, occupancy and drop logic of the frame FIFO; drives the RAM ports.
module fdo_ctrl import fdo_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic                action,
   input  cfg_type             cfg,
   output logic                we,
   output logic [PTR_BITS-1:0] waddr,
   output logic                re,
   output logic [PTR_BITS-1:0] raddr,
   output rsp_type             rsp
);

   logic [PTR_BITS-1:0]  head_ff, head_in;
   logic [PTR_BITS-1:0]  tail_ff, tail_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   rsp_type              rsp_ff, rsp_in;
   logic [WIDE_BITS-1:0] max_w, disc_w, count_w, limit_w, want_w, drop_w;
   logic [WIDE_BITS:0]   head_sum;
   logic [CNT_BITS-1:0]  count_kept;

   always_comb begin
      max_w   = WIDE_BITS'(cfg.max_entries);
      disc_w  = WIDE_BITS'(cfg.discard_count);
      count_w = WIDE_BITS'(count_ff);

      limit_w = (max_w == '0) ? WIDE_BITS'(1) : max_w;
      if (limit_w > WIDE_BITS'(DEPTH)) begin
         limit_w = WIDE_BITS'(DEPTH);
      end
      want_w = (disc_w == '0) ? WIDE_BITS'(1) : disc_w;

      drop_w = '0;
      if (count_w >= limit_w) begin
         drop_w = (want_w < count_w) ? want_w : count_w;
      end

      head_sum = (WIDE_BITS + 1)'(head_ff) + (WIDE_BITS + 1)'(drop_w);
      if (head_sum >= (WIDE_BITS + 1)'(DEPTH)) begin
         head_sum = head_sum - (WIDE_BITS + 1)'(DEPTH);
      end
      count_kept = count_ff - CNT_BITS'(drop_w);
   end

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      we       = 1'b0;
      re       = 1'b0;
      waddr    = tail_ff;
      raddr    = head_ff;
      rsp_in   = '0;
      rsp_in.strobe = accept;
      if (accept) begin
         if (action == ACTION_PUSH) begin
            // drop from the head first, then append; never overflows
            we             = 1'b1;
            head_in        = PTR_BITS'(head_sum);
            tail_in        = next_ptr(tail_ff);
            count_in       = count_kept + 1'b1;
            rsp_in.dropped = REG_BITS'(drop_w);
         end else if (count_ff != '0) begin
            re                 = 1'b1;
            head_in            = next_ptr(head_ff);
            count_in           = count_ff - 1'b1;
            rsp_in.frame_valid = 1'b1;
         end
      end
      rsp_in.occupancy = REG_BITS'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         rsp_ff   <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         rsp_ff   <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(DEPTH))
      else $error("occupancy above depth");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == tail_ff))
      else $error("empty queue with head and tail apart");

   a_pop_word: assert property (@(posedge clock) disable iff (reset)
      (accept && action == ACTION_POP && count_ff != '0) |=>
         (rsp_ff.frame_valid && count_ff == CNT_BITS'($past(count_ff) - 1'b1)))
      else $error("pop of held word not reported");

   a_push_word: assert property (@(posedge clock) disable iff (reset)
      (accept && action == ACTION_PUSH) |=>
         (count_ff != '0 && rsp_ff.strobe && !rsp_ff.frame_valid))
      else $error("push result wrong");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_ff.strobe)
      else $error("result without accepted word");

endmodule

// ===== src/frame_drop_oldest_fifo_top.sv =====
// Top level of the drop-oldest frame FIFO: config registers, RAM and result port.
//
//   channel  handshake               ports
//   request  start & !busy           req_action, req_frame_in
//   result   rsp_strobe, no stall    rsp_frame_out, rsp_frame_valid, rsp_dropped,
//                                    rsp_occupancy
//   csr      csr_valid & csr_ready   csr_index, csr_data
//
// One word per cycle; busy stays low. The result of a word shows in the cycle
// after it is accepted, since the result fields and the handle RAM read are both registered.
// Synchronous reset empties the queue and loads max_entries 16, discard_count 1.
// Handle RAM contents are not cleared; only written entries are ever read.
// The receiver cannot stall: each result is on the port for one cycle.
module frame_drop_oldest_fifo_top import fdo_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_action,
   input  logic [FRAME_BITS-1:0]   req_frame_in,
   output logic                    rsp_strobe,
   output logic [FRAME_BITS-1:0]   rsp_frame_out,
   output logic                    rsp_frame_valid,
   output logic [REG_BITS-1:0]     rsp_dropped,
   output logic [REG_BITS-1:0]     rsp_occupancy,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [REG_BITS-1:0]     csr_data
);

   cfg_type                 cfg_ff, cfg_in;
   rsp_type                 rsp;
   logic                    accept;
   logic                    we, re;
   logic [PTR_BITS-1:0]     waddr, raddr;
   logic [HANDLE_BITS-1:0]  rdata;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start & ~busy;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MAX_ENTRIES:   cfg_in.max_entries   = csr_data;
            CSR_DISCARD_COUNT: cfg_in.discard_count = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_entries   <= MAX_ENTRIES_RST;
         cfg_ff.discard_count <= DISCARD_COUNT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   fdo_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .action (req_action),
      .cfg    (cfg_ff),
      .we     (we),
      .waddr  (waddr),
      .re     (re),
      .raddr  (raddr),
      .rsp    (rsp)
   );

   fdo_ram #(
      .WORDS (DEPTH),
      .WIDTH (HANDLE_BITS),
      .ABITS (PTR_BITS)
   ) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (HANDLE_BITS'(req_frame_in)),
      .re    (re),
      .raddr (raddr),
      .rdata (rdata)
   );

   assign rsp_strobe      = rsp.strobe;
   assign rsp_frame_valid = rsp.frame_valid;
   assign rsp_dropped     = rsp.dropped;
   assign rsp_occupancy   = rsp.occupancy;
   assign rsp_frame_out   = rsp.frame_valid ? FRAME_BITS'(rdata) : '0;

endmodule
